// ===== rtl/core/brb_pkg.sv =====
// Package with the opcode and status codes and the fixed field widths of the byte ring buffer.
`timescale 1ns / 1ps

package brb_pkg;

  localparam int unsigned CAP_W   = 13;  // capacity, fill level and free space
  localparam int unsigned CNT_W   = 4;   // byte count field
  localparam int unsigned WORD_W  = 64;  // packed byte word
  localparam int unsigned LANE_W  = 3;   // byte lane index within the word

  typedef enum logic [2:0] {
    OP_INSERT = 3'd0,
    OP_GET    = 3'd1,
    OP_PEEK   = 3'd2,
    OP_REMOVE = 3'd3,
    OP_CLEAR  = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_FULL  = 2'd1,
    STS_SHORT = 2'd2
  } sts_t;

endpackage

// ===== rtl/core/byte_ring_buffer_core.sv =====
// Top level of the byte ring buffer: sequencer, byte-wide store and result registers.
`timescale 1ns / 1ps

// A command is taken when start is high and busy is low; busy then stays high until its
// result has been produced. The store has one byte-wide port, so bytes are moved one at a
// time: the sequencer evaluates the command, then writes, reads or skips its bytes, waits
// for the registered read on get and peek, and registers the result; clear, rejected or
// empty operations go from evaluation straight to the result. The result is shown for
// exactly one cycle under out_valid and the receiver cannot hold it off; a new command may
// be started in that same cycle. Writing cfg_wr_data sets the capacity (0 is taken as 1,
// values above DEPTH as DEPTH) and empties the buffer; write it only while busy is low.
module byte_ring_buffer_core #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned LANES = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [2:0]                    in_opcode,
  input  logic [brb_pkg::CNT_W-1:0]     in_byte_count,
  input  logic [brb_pkg::WORD_W-1:0]    in_write_bytes,
  output logic                          out_valid,
  output logic [1:0]                    out_status,
  output logic [brb_pkg::WORD_W-1:0]    out_read_bytes,
  output logic [brb_pkg::CAP_W-1:0]     out_fill_level,
  output logic [brb_pkg::CAP_W-1:0]     out_free_space,
  input  logic                          cfg_wr_en,
  input  logic [brb_pkg::CAP_W-1:0]     cfg_wr_data
);

  localparam int unsigned PTR_W   = $clog2(DEPTH);
  localparam int unsigned CMP_W   = (PTR_W + 1 > brb_pkg::CAP_W) ? PTR_W + 1 : brb_pkg::CAP_W;
  localparam int unsigned CAP_RST = (DEPTH < 4096) ? DEPTH : 4096;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WRITE,
    S_READ,
    S_SKIP,
    S_WAIT,
    S_DONE
  } state_t;

  state_t                       state_r;
  logic [2:0]                   op_r;
  logic [brb_pkg::CNT_W-1:0]    cnt_r;
  logic [brb_pkg::LANE_W-1:0]   idx_r;
  logic [brb_pkg::LANE_W-1:0]   rd_lane_r;
  logic                         rd_pend_r;
  logic [brb_pkg::WORD_W-1:0]   data_r;
  logic [brb_pkg::WORD_W-1:0]   rd_word_r;
  logic [1:0]                   sts_r;
  logic [PTR_W-1:0]             ptr_r;
  logic [PTR_W-1:0]             rd_ptr_r;
  logic [PTR_W-1:0]             wr_ptr_r;
  logic [brb_pkg::CAP_W-1:0]    held_r;
  logic [brb_pkg::CAP_W-1:0]    cap_r;

  logic                         out_valid_r;
  logic [1:0]                   out_status_r;
  logic [brb_pkg::WORD_W-1:0]   out_read_bytes_r;
  logic [brb_pkg::CAP_W-1:0]    out_fill_level_r;
  logic [brb_pkg::CAP_W-1:0]    out_free_space_r;

  logic [brb_pkg::CNT_W-1:0]    cnt_sat;
  logic [CMP_W-1:0]             ptr_inc;
  logic [PTR_W-1:0]             ptr_adv;
  logic                         last_step;
  logic [brb_pkg::CAP_W:0]      ins_total;
  logic                         short_held;
  logic [brb_pkg::CAP_W-1:0]    cap_nxt;

  logic [7:0]                   mem [DEPTH];
  logic                         mem_we;
  logic [7:0]                   mem_q;

  assign cnt_sat = (in_byte_count > brb_pkg::CNT_W'(LANES)) ? brb_pkg::CNT_W'(LANES)
                                                            : in_byte_count;

  // The walking pointer wraps at the capacity in use, not at the physical depth.
  assign ptr_inc   = CMP_W'(ptr_r) + CMP_W'(1);
  assign ptr_adv   = (ptr_inc >= CMP_W'(cap_r)) ? '0 : ptr_inc[PTR_W-1:0];
  assign last_step = ({1'b0, idx_r} == brb_pkg::CNT_W'(cnt_r - brb_pkg::CNT_W'(1)));

  assign ins_total  = {1'b0, held_r} + (brb_pkg::CAP_W + 1)'(cnt_r);
  assign short_held = (brb_pkg::CAP_W'(cnt_r) > held_r);

  always_comb begin
    if (cfg_wr_data == '0) begin
      cap_nxt = brb_pkg::CAP_W'(1);
    end else if (32'(cfg_wr_data) > 32'(DEPTH)) begin
      cap_nxt = brb_pkg::CAP_W'(DEPTH);
    end else begin
      cap_nxt = cfg_wr_data;
    end
  end

  assign mem_we = (state_r == S_WRITE);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[ptr_r] <= data_r[idx_r*8 +: 8];
    end
    mem_q <= mem[ptr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rd_ptr_r    <= '0;
      wr_ptr_r    <= '0;
      held_r      <= '0;
      cap_r       <= brb_pkg::CAP_W'(CAP_RST);
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      rd_pend_r   <= 1'b0;
      if (rd_pend_r) begin
        rd_word_r[rd_lane_r*8 +: 8] <= mem_q;
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            op_r      <= in_opcode;
            cnt_r     <= cnt_sat;
            data_r    <= in_write_bytes;
            rd_word_r <= '0;
            idx_r     <= '0;
            sts_r     <= brb_pkg::STS_OK;
            state_r   <= S_EVAL;
          end
        end
        S_EVAL: begin
          state_r <= S_DONE;
          case (op_r)
            brb_pkg::OP_INSERT: begin
              if (ins_total > (brb_pkg::CAP_W + 1)'(cap_r)) begin
                sts_r <= brb_pkg::STS_FULL;
              end else if (cnt_r != '0) begin
                ptr_r   <= wr_ptr_r;
                state_r <= S_WRITE;
              end
            end
            brb_pkg::OP_GET, brb_pkg::OP_PEEK: begin
              if (short_held) begin
                sts_r <= brb_pkg::STS_SHORT;
              end else if (cnt_r != '0) begin
                ptr_r   <= rd_ptr_r;
                state_r <= S_READ;
              end
            end
            brb_pkg::OP_REMOVE: begin
              if (short_held) begin
                sts_r <= brb_pkg::STS_SHORT;
              end else if (cnt_r != '0) begin
                ptr_r   <= rd_ptr_r;
                state_r <= S_SKIP;
              end
            end
            brb_pkg::OP_CLEAR: begin
              rd_ptr_r <= '0;
              wr_ptr_r <= '0;
              held_r   <= '0;
            end
            default: begin
            end
          endcase
        end
        S_WRITE: begin
          ptr_r <= ptr_adv;
          idx_r <= idx_r + brb_pkg::LANE_W'(1);
          if (last_step) begin
            wr_ptr_r <= ptr_adv;
            held_r   <= held_r + brb_pkg::CAP_W'(cnt_r);
            state_r  <= S_DONE;
          end
        end
        S_READ: begin
          // The store's read data is registered, so the lane index is registered alongside it.
          rd_pend_r <= 1'b1;
          rd_lane_r <= idx_r;
          ptr_r     <= ptr_adv;
          idx_r     <= idx_r + brb_pkg::LANE_W'(1);
          if (last_step) begin
            state_r <= S_WAIT;
          end
        end
        S_WAIT: begin
          if (op_r == brb_pkg::OP_GET) begin
            rd_ptr_r <= ptr_r;
            held_r   <= held_r - brb_pkg::CAP_W'(cnt_r);
          end
          state_r <= S_DONE;
        end
        S_SKIP: begin
          ptr_r <= ptr_adv;
          idx_r <= idx_r + brb_pkg::LANE_W'(1);
          if (last_step) begin
            rd_ptr_r <= ptr_adv;
            held_r   <= held_r - brb_pkg::CAP_W'(cnt_r);
            state_r  <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_r      <= 1'b1;
          out_status_r     <= sts_r;
          out_read_bytes_r <= rd_word_r;
          out_fill_level_r <= held_r;
          out_free_space_r <= cap_r - held_r;
          state_r          <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // A capacity write empties the buffer; user must do it only while idle; unenforced.
      if (cfg_wr_en) begin
        cap_r    <= cap_nxt;
        rd_ptr_r <= '0;
        wr_ptr_r <= '0;
        held_r   <= '0;
      end
    end
  end

  assign busy           = (state_r != S_IDLE);
  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_read_bytes = out_read_bytes_r;
  assign out_fill_level = out_fill_level_r;
  assign out_free_space = out_free_space_r;

  // Every transfer of a result ends its command, so the result strobe is never held over.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  // The bytes held never exceed the capacity in use.
  a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= cap_r)
    else $error("fill level above capacity");

  // Fill level and free space of a result always add up to the capacity.
  a_level_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (brb_pkg::CAP_W'(out_fill_level + out_free_space) == cap_r))
    else $error("fill level and free space disagree with capacity");

  // An accepted command keeps the block busy in the next cycle.
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

endmodule
